// File: rtl/fmt_pkg.sv
`default_nettype none
package fmt_pkg;
   localparam int unsigned SIG_W  = 24;
   localparam int unsigned PROD_W = 48;
   localparam int unsigned EXP_W  = 8;
   localparam logic [EXP_W-1:0] EXP_MAX_FIELD = 8'hFF;
   localparam logic [9:0] EXP_BIAS = 10'd127;
   localparam logic [9:0] EXP_OVF  = 10'd255;
   localparam logic [31:0] POS_INFINITY = 32'h7F80_0000;
   localparam logic [31:0] NEG_INFINITY = 32'hFF80_0000;

   typedef enum logic [1:0] {
      STATUS_NORMAL    = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      logic [31:0] operand_a;
      logic [31:0] operand_b;
   } req_type;

   typedef struct packed {
      logic [31:0] product;
      logic [1:0]  status;
   } rsp_type;

   // operands after unpacking, ahead of the multiply
   typedef struct packed {
      logic             sign;
      logic             zero;
      logic signed [9:0] exp;
      logic [SIG_W-1:0] sig_a;
      logic [SIG_W-1:0] sig_b;
   } unp_type;

   // after the multiply
   typedef struct packed {
      logic              sign;
      logic              zero;
      logic signed [9:0] exp;
      logic [PROD_W-1:0] prod;
   } mul_type;
endpackage
`default_nettype wire

// File: rtl/float32_multiplier_truncating_core.sv
// Truncating single-precision multiplier, pipelined.
// Channels: req_ carries two float32 bit patterns, rsp_ carries the truncated
// product and a status code (normal, overflow to infinity, underflow to +0).
// Each channel uses valid/stall; an item moves when valid is high and stall low.
// Pipeline: unpack register, multiply register, pack/output register. An item
// accepted at one edge moves through the multiply register into the output
// register, and rsp_valid rises once it is loaded there; the receiver can take
// the item from then on, whenever rsp_stall is low.
// Throughput: one item per cycle unless stalled; one 24x24 multiplier stage.
// When the receiver stalls, the whole pipe holds; req_stall rises only while
// the output register is full and stalled, so nothing is lost or repeated.
// Reset clears all valid bits; the pipe starts empty and accepts at once.
`default_nettype none
module float32_multiplier_truncating_core (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   req_valid,
   output logic                  req_stall,
   input  wire fmt_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire                   rsp_stall,
   output fmt_pkg::rsp_type      rsp_data
);
   fmt_pkg::unp_type unp_in, unp_ff;
   fmt_pkg::mul_type mul_ff;
   fmt_pkg::rsp_type rsp_in, rsp_ff;
   logic v1_ff, v2_ff, v3_ff;
   logic advance;

   // hold everything while the output item is stalled
   assign advance   = !(v3_ff && rsp_stall);
   assign req_stall = !advance;

   fmt_unpack u_unpack (.req(req_data), .unp(unp_in));
   fmt_pack   u_pack   (.mul(mul_ff), .rsp(rsp_in));

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (advance) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         unp_ff      <= unp_in;
         mul_ff.sign <= unp_ff.sign;
         mul_ff.zero <= unp_ff.zero;
         mul_ff.exp  <= unp_ff.exp;
         mul_ff.prod <= unp_ff.sig_a * unp_ff.sig_b;
         rsp_ff      <= rsp_in;
      end
   end

   assign rsp_valid = v3_ff;
   assign rsp_data  = rsp_ff;
endmodule
`default_nettype wire

// File: rtl/fmt_unpack.sv
`default_nettype none
module fmt_unpack (
   input  wire fmt_pkg::req_type req,
   output fmt_pkg::unp_type      unp
);
   logic [7:0] ea;
   logic [7:0] eb;
   always_comb begin
      ea = req.operand_a[30:23];
      eb = req.operand_b[30:23];
      unp.sign  = req.operand_a[31] ^ req.operand_b[31];
      unp.zero  = (ea == 8'd0) || (eb == 8'd0);
      unp.exp   = $signed({2'b00, ea} + {2'b00, eb} - fmt_pkg::EXP_BIAS);
      unp.sig_a = {1'b1, req.operand_a[22:0]};
      unp.sig_b = {1'b1, req.operand_b[22:0]};
   end
endmodule
`default_nettype wire

// File: rtl/fmt_pack.sv
`default_nettype none
module fmt_pack (
   input  wire fmt_pkg::mul_type mul,
   output fmt_pkg::rsp_type      rsp
);
   logic signed [9:0] exp_fin;
   logic [22:0]       frac;
   always_comb begin
      if (mul.prod[47]) begin
         exp_fin = mul.exp + 10'sd1;
         frac    = mul.prod[46:24];
      end else begin
         exp_fin = mul.exp;
         frac    = mul.prod[45:23];
      end
      if (mul.zero) begin
         rsp.product = 32'd0;
         rsp.status  = fmt_pkg::STATUS_UNDERFLOW;
      end else if (exp_fin >= $signed(fmt_pkg::EXP_OVF)) begin
         rsp.product = mul.sign ? fmt_pkg::NEG_INFINITY : fmt_pkg::POS_INFINITY;
         rsp.status  = fmt_pkg::STATUS_OVERFLOW;
      end else if (exp_fin <= 10'sd0) begin
         rsp.product = 32'd0;
         rsp.status  = fmt_pkg::STATUS_UNDERFLOW;
      end else begin
         rsp.product = {mul.sign, exp_fin[7:0], frac};
         rsp.status  = fmt_pkg::STATUS_NORMAL;
      end
   end
endmodule
`default_nettype wire

// File: rtl/fmt_checker.sv
`default_nettype none
module fmt_checker (
   input wire                   clock,
   input wire                   reset,
   input wire                   req_valid,
   input wire                   req_stall,
   input wire                   rsp_valid,
   input wire                   rsp_stall,
   input wire fmt_pkg::rsp_type rsp_data
);
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == fmt_pkg::STATUS_NORMAL ||
                     rsp_data.status == fmt_pkg::STATUS_OVERFLOW ||
                     rsp_data.status == fmt_pkg::STATUS_UNDERFLOW))
      else $error("bad status");
   a_uflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == fmt_pkg::STATUS_UNDERFLOW
      |-> rsp_data.product == 32'd0)
      else $error("underflow not +0");
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall ##1 !rsp_stall ##1 !rsp_stall |=> rsp_valid)
      else $error("item lost");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled item changed");
   a_nostall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("stall while output empty");
endmodule

bind float32_multiplier_truncating_core fmt_checker u_fmt_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data));
`default_nettype wire
